// ----- rtl/memory_pattern_test_sequencer_top_assert.svh -----
// Assertion macros for the memory pattern test sequencer.
// Depends on nothing; included by the RTL files that carry assertions.
`ifndef MEMORY_PATTERN_TEST_SEQUENCER_TOP_ASSERT_SVH
`define MEMORY_PATTERN_TEST_SEQUENCER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define MPTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("mpts assertion failed");
`define MPTS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mpts assertion failed");
`define MPTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mpts assertion failed");
`else
`define MPTS_ASSERT(lbl, clk, rstn, prop)
`define MPTS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define MPTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/mpts_pkg.sv -----
// Shared types, constants and the pattern function of the memory pattern test sequencer.
// Depends on nothing.
`default_nettype none

package mpts_pkg;

  localparam int unsigned MAX_WORDS = 32768;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned ADDR_W    = 15;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_IDLE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd3;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NARROW_WORDS  = 2'd1;

  localparam logic [PHASE_W-1:0] PHASE_ONES  = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_ZEROS = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_AA    = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_55    = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_ADDR  = 3'd4;

  localparam logic [DATA_W-1:0] PAT_ONES    = 8'b11111111;
  localparam logic [DATA_W-1:0] PAT_ZEROS   = 8'b00000000;
  localparam logic [DATA_W-1:0] PAT_AA      = 8'b10101010;
  localparam logic [DATA_W-1:0] PAT_55      = 8'b01010101;
  localparam logic [DATA_W-1:0] NARROW_MASK = 8'h0F;

  localparam logic [CNT_W-1:0] MAX_WORDS_C = CNT_W'(MAX_WORDS);

  typedef struct packed {
    logic [CNT_W-1:0] address_count;
    logic             narrow_words;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic [DATA_W-1:0] read_data;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  access_kind;
    logic [ADDR_W-1:0]  access_address;
    logic [DATA_W-1:0]  write_value;
    logic [PHASE_W-1:0] phase_number;
    logic               check_valid;
    logic               mismatch;
    logic [ADDR_W-1:0]  checked_address;
    logic [DATA_W-1:0]  expected_value;
    logic [DATA_W-1:0]  got_value;
  } result_t;

  function automatic logic [DATA_W-1:0] pattern_for(input logic [PHASE_W-1:0] phase,
                                                    input logic [DATA_W-1:0]  addr_lo);
    logic [DATA_W-1:0] pat;
    case (phase)
      PHASE_ONES:  pat = PAT_ONES;
      PHASE_ZEROS: pat = PAT_ZEROS;
      PHASE_AA:    pat = PAT_AA;
      PHASE_55:    pat = PAT_55;
      default:     pat = addr_lo;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mpts_cfg.sv -----
// Configuration registers of the memory pattern test sequencer.
// Depends on mpts_pkg.
`default_nettype none

module mpts_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [mpts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mpts_pkg::CNT_W-1:0]     cfg_data_i,
  output mpts_pkg::cfg_t                      cfg_o
);

  mpts_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mpts_pkg::CFG_ADDRESS_COUNT: cfg_d.address_count = cfg_data_i;
        mpts_pkg::CFG_NARROW_WORDS:  cfg_d.narrow_words  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/mpts_in_stage.sv -----
// Input register of the memory pattern test sequencer; issues one step per held item.
// Depends on mpts_pkg.
`default_nettype none

module mpts_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire mpts_pkg::item_t item_i,
  input  wire logic           out_ready_i,
  output logic                step_o,
  output mpts_pkg::item_t     item_o
);

  logic            valid_q, valid_d;
  mpts_pkg::item_t item_q;
  logic            accept;

  assign step_o     = valid_q && out_ready_i;
  assign in_stall_o = valid_q && !out_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (step_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

// ----- rtl/mpts_seq.sv -----
// Sequencer state and single-step logic: phase, pass, address counter and pending check.
// Depends on mpts_pkg and memory_pattern_test_sequencer_top_assert.svh.
`default_nettype none
`include "memory_pattern_test_sequencer_top_assert.svh"

module mpts_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire mpts_pkg::item_t item_i,
  input  wire mpts_pkg::cfg_t  cfg_i,
  output mpts_pkg::result_t    result_o
);

  logic                           running_q, running_d;
  logic [mpts_pkg::PHASE_W-1:0]   phase_q, phase_d;
  logic                           pass_q, pass_d;
  logic [mpts_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                           pend_q, pend_d;
  logic [mpts_pkg::ADDR_W-1:0]    pend_addr_q, pend_addr_d;
  logic [mpts_pkg::DATA_W-1:0]    pend_exp_q, pend_exp_d;

  logic [mpts_pkg::DATA_W-1:0]    mask;
  logic [mpts_pkg::DATA_W-1:0]    got;
  logic [mpts_pkg::CNT_W-1:0]     words;
  logic [mpts_pkg::CNT_W-1:0]     addr;
  logic [mpts_pkg::PHASE_W-1:0]   phase;
  logic                           pass;
  logic                           finish;
  logic [mpts_pkg::DATA_W-1:0]    pat;
  logic                           read_issued;

  assign mask  = cfg_i.narrow_words ? mpts_pkg::NARROW_MASK : mpts_pkg::PAT_ONES;
  assign got   = item_i.read_data & mask;
  assign words = (cfg_i.address_count > mpts_pkg::MAX_WORDS_C) ? mpts_pkg::MAX_WORDS_C
                                                               : cfg_i.address_count;

  // The word count is reached: wrap to address zero and move to the next pass.
  always_comb begin
    addr   = cnt_q;
    phase  = phase_q;
    pass   = pass_q;
    finish = 1'b0;
    if (cnt_q >= words) begin
      addr = '0;
      if (!pass_q) begin
        pass = 1'b1;
      end else begin
        pass  = 1'b0;
        phase = phase_q + 1'b1;
      end
      finish = (words == '0) || (phase > mpts_pkg::PHASE_ADDR);
    end
  end

  assign pat = mpts_pkg::pattern_for(phase, addr[mpts_pkg::DATA_W-1:0]);

  always_comb begin
    running_d   = running_q;
    phase_d     = phase_q;
    pass_d      = pass_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    pend_exp_d  = pend_exp_q;
    result_o    = '0;
    if (step_i) begin
      if (item_i.command == mpts_pkg::CMD_START) begin
        running_d   = 1'b1;
        phase_d     = '0;
        pass_d      = 1'b0;
        cnt_d       = '0;
        pend_d      = 1'b0;
        pend_addr_d = '0;
        pend_exp_d  = '0;
      end else begin
        if (pend_q) begin
          result_o.check_valid     = 1'b1;
          result_o.mismatch        = (got != pend_exp_q);
          result_o.checked_address = pend_addr_q;
          result_o.expected_value  = pend_exp_q;
          result_o.got_value       = got;
          pend_d                   = 1'b0;
        end
        if (running_q) begin
          if (finish) begin
            running_d            = 1'b0;
            phase_d              = '0;
            pass_d               = 1'b0;
            cnt_d                = '0;
            result_o.access_kind = mpts_pkg::KIND_DONE;
          end else begin
            result_o.access_address = addr[mpts_pkg::ADDR_W-1:0];
            result_o.phase_number   = phase;
            if (!pass) begin
              result_o.access_kind = mpts_pkg::KIND_WRITE;
              result_o.write_value = pat;
            end else begin
              result_o.access_kind = mpts_pkg::KIND_READ;
              pend_d               = 1'b1;
              pend_addr_d          = addr[mpts_pkg::ADDR_W-1:0];
              pend_exp_d           = pat & mask;
            end
            phase_d = phase;
            pass_d  = pass;
            cnt_d   = addr + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      phase_q     <= '0;
      pass_q      <= 1'b0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      pend_exp_q  <= '0;
    end else begin
      running_q   <= running_d;
      phase_q     <= phase_d;
      pass_q      <= pass_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      pend_addr_q <= pend_addr_d;
      pend_exp_q  <= pend_exp_d;
    end
  end

  assign read_issued = step_i && (result_o.access_kind == mpts_pkg::KIND_READ);

  `MPTS_ASSERT(a_phase_range, clk_i, rst_ni, phase_q <= mpts_pkg::PHASE_ADDR)
  `MPTS_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= mpts_pkg::MAX_WORDS_C)
  `MPTS_ASSERT_IMPLY(a_idle_home, clk_i, rst_ni, !running_q, (phase_q == '0) && !pass_q)
  `MPTS_ASSERT_NEXT(a_read_pends, clk_i, rst_ni, read_issued, pend_q)

endmodule

`default_nettype wire

// ----- rtl/mpts_out_stage.sv -----
// Result register of the memory pattern test sequencer; holds a result while stalled.
// Depends on mpts_pkg.
`default_nettype none

module mpts_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire mpts_pkg::result_t result_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output mpts_pkg::result_t      result_o
);

  logic              valid_q, valid_d;
  mpts_pkg::result_t result_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

// ----- rtl/memory_pattern_test_sequencer_top.sv -----
// Top level of the memory pattern test sequencer: input register, sequencer, result register.
// Depends on mpts_pkg, mpts_cfg, mpts_in_stage, mpts_seq and mpts_out_stage.
//
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   command_i, read_data_i
// out      source     out_valid_o / out_stall_i access_kind_o ... got_value_o
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each item passes through the input register and then through the step logic into the result
// register. One item is accepted per cycle while the output does not stall.
// Reset clears the sequencer to idle, the configuration to zero and both stages to empty.
// A stall on the output holds the result register and, once the input register is full,
// raises in_stall_o in the same cycle.
`default_nettype none

module memory_pattern_test_sequencer_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               command_i,
  input  wire logic [mpts_pkg::DATA_W-1:0]        read_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [mpts_pkg::KIND_W-1:0]             access_kind_o,
  output logic [mpts_pkg::ADDR_W-1:0]             access_address_o,
  output logic [mpts_pkg::DATA_W-1:0]             write_value_o,
  output logic [mpts_pkg::PHASE_W-1:0]            phase_number_o,
  output logic                                    check_valid_o,
  output logic                                    mismatch_o,
  output logic [mpts_pkg::ADDR_W-1:0]             checked_address_o,
  output logic [mpts_pkg::DATA_W-1:0]             expected_value_o,
  output logic [mpts_pkg::DATA_W-1:0]             got_value_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [mpts_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [mpts_pkg::CNT_W-1:0]         cfg_data_i
);

  mpts_pkg::cfg_t    cfg;
  mpts_pkg::item_t   in_item;
  mpts_pkg::item_t   step_item;
  mpts_pkg::result_t step_result;
  mpts_pkg::result_t out_result;
  logic              out_ready;
  logic              step;

  assign in_item.command   = command_i;
  assign in_item.read_data = read_data_i;

  mpts_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mpts_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (in_item),
    .out_ready_i (out_ready),
    .step_o      (step),
    .item_o      (step_item)
  );

  mpts_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (step_item),
    .cfg_i    (cfg),
    .result_o (step_result)
  );

  mpts_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (step_result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign access_kind_o     = out_result.access_kind;
  assign access_address_o  = out_result.access_address;
  assign write_value_o     = out_result.write_value;
  assign phase_number_o    = out_result.phase_number;
  assign check_valid_o     = out_result.check_valid;
  assign mismatch_o        = out_result.mismatch;
  assign checked_address_o = out_result.checked_address;
  assign expected_value_o  = out_result.expected_value;
  assign got_value_o       = out_result.got_value;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for memory_pattern_test_sequencer_top: drives commands and read data,
// predicts every access and check result in step with the block, and compares each transfer.
// Depends on mpts_pkg and the RTL of the sequencer.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mpts_pkg::*;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 command_i   = CMD_ADVANCE;
  logic [DATA_W-1:0]    read_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [KIND_W-1:0]    access_kind_o;
  logic [ADDR_W-1:0]    access_address_o;
  logic [DATA_W-1:0]    write_value_o;
  logic [PHASE_W-1:0]   phase_number_o;
  logic                 check_valid_o;
  logic                 mismatch_o;
  logic [ADDR_W-1:0]    checked_address_o;
  logic [DATA_W-1:0]    expected_value_o;
  logic [DATA_W-1:0]    got_value_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CNT_W-1:0]     cfg_data_i  = '0;

  // Register indexes that select no register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // Predicted configuration and sequencer state.
  logic [CNT_W-1:0]   cfg_count;
  logic               cfg_narrow;
  logic               seq_running;
  logic [PHASE_W-1:0] seq_phase;
  logic               seq_read_pass;
  logic [CNT_W-1:0]   seq_address;
  logic               chk_pending;
  logic [ADDR_W-1:0]  chk_address;
  logic [DATA_W-1:0]  chk_expected;

  result_t expected_accesses[$];
  int      mismatches    = 0;
  int      results_seen  = 0;
  int      sent_items    = 0;
  int      send_idle_pct = 19;
  int      recv_idle_pct = 49;
  int      hold_request  = 0;
  int      hold_left     = 0;

  memory_pattern_test_sequencer_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .read_data_i      (read_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .access_kind_o    (access_kind_o),
    .access_address_o (access_address_o),
    .write_value_o    (write_value_o),
    .phase_number_o   (phase_number_o),
    .check_valid_o    (check_valid_o),
    .mismatch_o       (mismatch_o),
    .checked_address_o(checked_address_o),
    .expected_value_o (expected_value_o),
    .got_value_o      (got_value_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("status: fail");
    $finish;
  end

  function automatic result_t next_access(input logic cmd, input logic [DATA_W-1:0] rdata);
    result_t           r;
    logic [DATA_W-1:0] nmask;
    logic [DATA_W-1:0] got;
    logic [DATA_W-1:0] pat;
    int unsigned       words;
    r = '0;
    nmask = cfg_narrow ? NARROW_MASK : 8'hFF;
    if (cmd == CMD_START) begin
      seq_running   = 1'b1;
      seq_phase     = PHASE_ONES;
      seq_read_pass = 1'b0;
      seq_address   = '0;
      chk_pending   = 1'b0;
      chk_address   = '0;
      chk_expected  = '0;
      return r;
    end
    if (chk_pending) begin
      got = rdata & nmask;
      r.check_valid     = 1'b1;
      r.mismatch        = (got != chk_expected);
      r.checked_address = chk_address;
      r.expected_value  = chk_expected;
      r.got_value       = got;
      chk_pending       = 1'b0;
    end
    if (!seq_running) return r;
    words = (cfg_count > MAX_WORDS) ? MAX_WORDS : cfg_count;
    if (seq_address >= words) begin
      seq_address = '0;
      if (!seq_read_pass) begin
        seq_read_pass = 1'b1;
      end else begin
        seq_read_pass = 1'b0;
        seq_phase     = seq_phase + 1'b1;
      end
      if (words == 0 || seq_phase > PHASE_ADDR) begin
        seq_running   = 1'b0;
        seq_phase     = PHASE_ONES;
        seq_read_pass = 1'b0;
        r.access_kind = KIND_DONE;
        return r;
      end
    end
    case (seq_phase)
      PHASE_ONES:  pat = PAT_ONES;
      PHASE_ZEROS: pat = PAT_ZEROS;
      PHASE_AA:    pat = PAT_AA;
      PHASE_55:    pat = PAT_55;
      default:     pat = seq_address[DATA_W-1:0];
    endcase
    r.access_address = seq_address[ADDR_W-1:0];
    r.phase_number   = seq_phase;
    if (!seq_read_pass) begin
      r.access_kind = KIND_WRITE;
      r.write_value = pat;
    end else begin
      r.access_kind = KIND_READ;
      chk_pending   = 1'b1;
      chk_address   = seq_address[ADDR_W-1:0];
      chk_expected  = pat & nmask;
    end
    seq_address = seq_address + 1'b1;
    return r;
  endfunction

  // Read data that passes the pending check; the upper nibble is random in narrow mode.
  function automatic logic [DATA_W-1:0] matching_read_data();
    logic [DATA_W-1:0] d;
    d = DATA_W'($urandom);
    if (!chk_pending) return d;
    return cfg_narrow ? {d[7:4], chk_expected[3:0]} : chk_expected;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("%0t: result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned seen);
    if (want != seen) report_mismatch($sformatf("%s expected %0h got %0h", name, want, seen));
  endtask

  // Called and returning at a falling edge; valid stays high until the caller sends again or
  // drains.
  task automatic send_item(input logic cmd, input logic [DATA_W-1:0] rdata);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    read_data_i <= rdata;
    do @(posedge clk_i); while (in_stall_o);
    expected_accesses.push_back(next_access(cmd, rdata));
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_accesses.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ADDRESS_COUNT: cfg_count  = data;
      CFG_NARROW_WORDS:  cfg_narrow = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [CNT_W-1:0] count, input logic narrow);
    logic [CNT_W-1:0] junk;
    junk = CNT_W'($urandom);
    write_register(CFG_ADDRESS_COUNT, count);
    write_register(CFG_NARROW_WORDS, {junk[CNT_W-1:1], narrow});
  endtask

  task automatic test_directed();
    int i;
    send_item(CMD_ADVANCE, 8'hFF);
    send_item(CMD_START, 8'h00);
    send_item(CMD_ADVANCE, 8'h00);
    send_item(CMD_ADVANCE, 8'h5A);
    drain();
    configure(16'd1, 1'b0);
    send_item(CMD_START, 8'hFF);
    for (i = 0; i < 11; i++) send_item(CMD_ADVANCE, (i == 6) ? 8'h55 : matching_read_data());
    drain();
    configure(16'd1, 1'b1);
    send_item(CMD_START, 8'h00);
    send_item(CMD_ADVANCE, 8'h00);
    send_item(CMD_ADVANCE, 8'h00);
    send_item(CMD_START, 8'hAA);
    send_item(CMD_ADVANCE, 8'h00);
    send_item(CMD_ADVANCE, 8'h00);
    send_item(CMD_ADVANCE, 8'hFF);
    drain();
    write_register(CFG_SPARE_A, 16'hFFFF);
    write_register(CFG_SPARE_B, 16'h0000);
  endtask

  task automatic test_random(input int sidle, input int ridle, input int budget);
    int               target;
    int               roll;
    int               i;
    int               steps;
    int unsigned      words;
    logic [CNT_W-1:0] count;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    target = sent_items + budget;
    while (sent_items < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) count = 16'd0;
      else if (roll < 12) count = 16'd1;
      else if (roll < 20) begin
        case ($urandom_range(0, 2))
          0: count = MAX_WORDS_C;
          1: count = 16'hFFFF;
          default: count = CNT_W'($urandom_range(9, 65535));
        endcase
      end else count = CNT_W'($urandom_range(2, 8));
      words = (count > MAX_WORDS) ? MAX_WORDS : count;
      steps = (words > 8) ? $urandom_range(20, 80) : 10 * words + 1 + $urandom_range(0, 2);
      drain();
      configure(count, 1'($urandom_range(0, 1)));
      send_item(CMD_START, DATA_W'($urandom));
      for (i = 0; i < steps; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) send_item(CMD_START, DATA_W'($urandom));
        else if (roll < 12) send_item(CMD_ADVANCE, DATA_W'($urandom));
        else send_item(CMD_ADVANCE, matching_read_data());
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    configure(16'd4, 1'($urandom_range(0, 1)));
    send_item(CMD_START, DATA_W'($urandom));
    hold_request = 60;
    for (i = 0; i < 41; i++) send_item(CMD_ADVANCE, matching_read_data());
    drain();
  endtask

  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_accesses.size() == 0) begin
        report_mismatch("transfer with no access pending");
      end else begin
        want = expected_accesses.pop_front();
        compare_field("access_kind", want.access_kind, access_kind_o);
        compare_field("access_address", want.access_address, access_address_o);
        compare_field("write_value", want.write_value, write_value_o);
        compare_field("phase_number", want.phase_number, phase_number_o);
        compare_field("check_valid", want.check_valid, check_valid_o);
        compare_field("mismatch", want.mismatch, mismatch_o);
        compare_field("checked_address", want.checked_address, checked_address_o);
        compare_field("expected_value", want.expected_value, expected_value_o);
        compare_field("got_value", want.got_value, got_value_o);
      end
      results_seen++;
    end
  end

  initial begin
    cfg_count     = '0;
    cfg_narrow    = 1'b0;
    seq_running   = 1'b0;
    seq_phase     = PHASE_ONES;
    seq_read_pass = 1'b0;
    seq_address   = '0;
    chk_pending   = 1'b0;
    chk_address   = '0;
    chk_expected  = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(19, 49, 350);
    test_random(49, 19, 350);
    test_random(0, 0, 330);
    test_backpressure();
    drain();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/mpts_pkg.sv
rtl/mpts_cfg.sv
rtl/mpts_in_stage.sv
rtl/mpts_seq.sv
rtl/mpts_out_stage.sv
rtl/memory_pattern_test_sequencer_top.sv
tb/testbench.sv
